// File: design/bba_pkg.sv
// Shared constants, codes and types of the bitmap block allocator.
package bba_pkg;

    localparam int NUM_WORDS    = 64;
    localparam int WORD_BITS    = 64;
    localparam int BIT_AW       = $clog2(WORD_BITS);
    localparam int WORD_AW      = $clog2(NUM_WORDS);
    localparam int MAX_REQUEST  = 64;
    localparam int TOTAL_BLOCKS = NUM_WORDS * WORD_BITS;
    localparam int FREE_W       = $clog2(TOTAL_BLOCKS + 1);
    localparam int REM_W        = $clog2(MAX_REQUEST + 1);

    localparam int CNT_W        = 7;
    localparam int BID_W        = 12;
    localparam int LEFT_W       = 13;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_SPACE    = 2'd1,
        ST_DOUBLE_FREE = 2'd2
    } status_t;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_FETCH,
        S_ALLOC,
        S_FREE
    } state_t;

    typedef struct packed {
        logic              full;
        logic [BIT_AW-1:0] pos;
    } clear_info_t;

endpackage

// File: design/block_bitmap_allocator_unit.sv
// Bitmap block allocator: next-fit allocation and single-block free.
//
// Input channel (s_*): one request per item. tuser carries the request kind
// (allocate or free), tdata the count and the block id to free.
// Result channel (m_*): an allocate of N blocks (N capped at 64) gives N
// items, one block id each, tlast on the final one; a zero count, a
// no-space answer and every free give a single item with tlast set.
// Sequence: an item is taken when the block is idle and its output register
// is empty. An allocate then reads the bitmap (memory read, then load into
// the working word) and emits one block per cycle while the output is free;
// each word found full adds a check, a read and a load.
// A free goes through a read, a load, then an update with its answer.
// Requests answered at once (zero count, no space) give their item in the
// cycle after acceptance.
// Reset: the bitmap reads as all free through per-word valid bits, the
// free count is the full block count and the scan starts at word 0; no
// clearing sweep is needed.
// Back-pressure: when m_tready is low the result stays in the output
// register and the sequencer waits; no new request is taken until the
// last result of the current one has left.
module block_bitmap_allocator_unit
    import bba_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [6:0] alloc_count, [18:7] block_id, rest zero
    input  logic [0:0]  s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [11:0] out_block, [24:12] free_left, rest zero
    output logic [2:0]  m_tuser,   // [0] block_valid, [2:1] status
    output logic        m_tlast
);

    state_t                state_reg, state_next;
    logic [WORD_AW-1:0]    scan_word_reg, scan_word_next;
    logic [FREE_W-1:0]     free_total_reg, free_total_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic                  op_free_reg, op_free_next;
    logic [BID_W-1:0]      bid_reg, bid_next;
    logic [WORD_BITS-1:0]  word_reg, word_next;

    logic [WORD_BITS-1:0]  bitmap_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0]  row_vld_reg;
    logic [WORD_BITS-1:0]  rd_data_reg;
    logic                  rd_vld_reg;
    logic [WORD_AW-1:0]    rd_addr;
    logic                  mem_we;
    logic [WORD_BITS-1:0]  mem_wdata;

    logic                  m_valid_reg;
    logic [BID_W-1:0]      out_block_reg;
    logic                  blk_valid_reg;
    status_t               status_reg;
    logic                  last_reg;
    logic [LEFT_W-1:0]     free_left_reg;

    logic                  emit;
    logic [BID_W-1:0]      emit_block;
    logic                  emit_valid;
    status_t               emit_status;
    logic                  emit_last;

    logic                  s_accept;
    logic                  out_free;
    logic [CNT_W-1:0]      in_count;
    logic [BID_W-1:0]      in_bid;
    logic [REM_W-1:0]      cnt_sat;
    logic [BIT_AW-1:0]     free_bit;
    logic                  free_in_range;
    clear_info_t           clr_info;

    bba_find_clear u_find (
        .word (word_reg),
        .info (clr_info)
    );

    assign in_count = s_tdata[CNT_W-1:0];
    assign in_bid   = s_tdata[CNT_W +: BID_W];
    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign rd_addr       = op_free_reg ? WORD_AW'(bid_reg >> BIT_AW) : scan_word_reg;
    assign free_bit      = bid_reg[BIT_AW-1:0];
    assign free_in_range = 32'(bid_reg) < TOTAL_BLOCKS;
    assign cnt_sat       = (32'(in_count) > MAX_REQUEST) ? REM_W'(MAX_REQUEST)
                                                         : REM_W'(in_count);

    always_comb begin
        state_next      = state_reg;
        scan_word_next  = scan_word_reg;
        free_total_next = free_total_reg;
        rem_next        = rem_reg;
        op_free_next    = op_free_reg;
        bid_next        = bid_reg;
        word_next       = word_reg;
        mem_we          = 1'b0;
        mem_wdata       = word_reg;
        emit            = 1'b0;
        emit_block      = '0;
        emit_valid      = 1'b0;
        emit_status     = ST_OK;
        emit_last       = 1'b1;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (req_t'(s_tuser[0]) == REQ_FREE) begin
                        op_free_next = 1'b1;
                        bid_next     = in_bid;
                        state_next   = S_READ;
                    end else if (cnt_sat == '0) begin
                        emit = 1'b1;
                    end else if (32'(free_total_reg) < 32'(cnt_sat)) begin
                        emit        = 1'b1;
                        emit_status = ST_NO_SPACE;
                    end else begin
                        op_free_next = 1'b0;
                        rem_next     = cnt_sat;
                        state_next   = S_READ;
                    end
                end
            end
            S_READ: begin
                state_next = S_FETCH;
            end
            S_FETCH: begin
                // rows never written read as all free
                word_next  = rd_vld_reg ? rd_data_reg : '0;
                state_next = op_free_reg ? S_FREE : S_ALLOC;
            end
            S_ALLOC: begin
                if (clr_info.full) begin
                    scan_word_next = (32'(scan_word_reg) == NUM_WORDS - 1)
                                     ? '0 : scan_word_reg + 1'b1;
                    state_next     = S_READ;
                end else if (out_free) begin
                    word_next       = word_reg | (WORD_BITS'(1) << clr_info.pos);
                    mem_we          = 1'b1;
                    mem_wdata       = word_next;
                    free_total_next = free_total_reg - 1'b1;
                    emit            = 1'b1;
                    emit_valid      = 1'b1;
                    emit_block      = BID_W'({scan_word_reg, clr_info.pos});
                    emit_last       = (rem_reg == REM_W'(1));
                    rem_next        = rem_reg - 1'b1;
                    if (rem_reg == REM_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FREE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (free_in_range && word_reg[free_bit]) begin
                        word_next       = word_reg & ~(WORD_BITS'(1) << free_bit);
                        mem_we          = 1'b1;
                        mem_wdata       = word_next;
                        free_total_next = free_total_reg + 1'b1;
                    end else begin
                        emit_status = ST_DOUBLE_FREE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            scan_word_reg  <= '0;
            free_total_reg <= FREE_W'(TOTAL_BLOCKS);
            rem_reg        <= '0;
            op_free_reg    <= 1'b0;
            row_vld_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            scan_word_reg  <= scan_word_next;
            free_total_reg <= free_total_next;
            rem_reg        <= rem_next;
            op_free_reg    <= op_free_next;
            if (mem_we) begin
                row_vld_reg[rd_addr] <= 1'b1;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bid_reg    <= bid_next;
        word_reg   <= word_next;
        rd_vld_reg <= row_vld_reg[rd_addr];
        if (emit) begin
            out_block_reg <= emit_block;
            blk_valid_reg <= emit_valid;
            status_reg    <= emit_status;
            last_reg      <= emit_last;
            free_left_reg <= LEFT_W'(free_total_next);
        end
    end

    // bitmap store: one write port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bitmap_mem[rd_addr] <= mem_wdata;
        end
        rd_data_reg <= bitmap_mem[rd_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, free_left_reg, out_block_reg};
    assign m_tuser  = {status_reg, blk_valid_reg};
    assign m_tlast  = last_reg;

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(free_total_reg) <= TOTAL_BLOCKS)
        else $error("free count above total");

    a_alloc_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_valid) |=> (free_total_reg == $past(free_total_reg) - 1'b1))
        else $error("allocation did not take one block from the count");

    a_more_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !emit_last) |=> (state_reg != S_IDLE))
        else $error("sequencer idle before last item");

    a_alloc_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ALLOC) |-> (rem_reg != '0))
        else $error("allocating with nothing left to hand out");

    a_no_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && m_valid_reg) |-> m_tready)
        else $error("result overwritten while stalled");

endmodule

// File: design/bba_find_clear.sv
// Lowest-clear-bit finder over one bitmap word, two-level priority search.
module bba_find_clear
    import bba_pkg::*;
(
    input  logic [WORD_BITS-1:0] word,
    output clear_info_t          info
);

    localparam int GRP_W = 8;
    localparam int N_GRP = WORD_BITS / GRP_W;
    localparam int GRP_AW = $clog2(N_GRP);
    localparam int SUB_AW = $clog2(GRP_W);

    logic [WORD_BITS-1:0] inv;
    logic [N_GRP-1:0]     grp_any;
    logic [GRP_AW-1:0]    grp_sel;
    logic [GRP_W-1:0]     grp_bits;
    logic [SUB_AW-1:0]    sub_sel;

    assign inv = ~word;

    always_comb begin
        for (int g = 0; g < N_GRP; g++) begin
            grp_any[g] = |inv[g*GRP_W +: GRP_W];
        end
        // scan downward so the lowest hit wins
        grp_sel = '0;
        for (int g = N_GRP - 1; g >= 0; g--) begin
            if (grp_any[g]) begin
                grp_sel = GRP_AW'(g);
            end
        end
        grp_bits = inv[grp_sel*GRP_W +: GRP_W];
        sub_sel = '0;
        for (int b = GRP_W - 1; b >= 0; b--) begin
            if (grp_bits[b]) begin
                sub_sel = SUB_AW'(b);
            end
        end
        info.full = ~|grp_any;
        info.pos  = BIT_AW'({grp_sel, sub_sel});
    end

endmodule
